@@ design/mmb_pkg.sv @@
// Shared constants, types and register codes for the min/max bin one-hot encoder.
// No dependencies; mmb_ctrl, mmb_dp and the top level import this package.
`timescale 1ns / 1ps
package mmb_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SAMPLE_W    = 16;
  localparam int SCALE_W     = 16;
  localparam int DATA_W      = 32;
  localparam int ROW_W       = MAX_SAMPLES;
  localparam int NUM_W       = DATA_W + CNT_W;
  localparam int Q_W         = CNT_W;
  localparam int STEP_W      = $clog2(Q_W);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 1'd1;

  localparam logic [CNT_W-1:0]   SAMPLE_COUNT_RST = CNT_W'(50);
  localparam logic [SCALE_W-1:0] SCALE_FACTOR_RST = SCALE_W'(256);

  typedef struct packed {
    logic take;
    logic store;
    logic range_ld;
    logic diff;
    logic mul;
    logic div;
    logic row_wr;
    logic col_next;
    logic emit_sel;
    logic cap;
  } mmb_cmd_t;

  typedef struct packed {
    logic last_load;
    logic skip;
    logic div_last;
    logic bin_valid;
    logic last_col;
    logic out_fire;
    logic out_last;
  } mmb_status_t;

endpackage

@@ design/mmb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module mmb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/mmb_ctrl.sv @@
// Controller state machine: sequences load, bin computation and row emit.
// Depends on mmb_pkg; drives mmb_dp through command and status structs.
`timescale 1ns / 1ps
module mmb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mmb_pkg::mmb_status_t status,
  output mmb_pkg::mmb_cmd_t    cmd
);
  import mmb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STORE,
    S_BRD,
    S_BDIFF,
    S_BMUL,
    S_BDIV,
    S_BRROW,
    S_BWROW,
    S_BNEXT,
    S_ERD,
    S_ECAP,
    S_EWAIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_STORE;
      S_STORE: state_nxt = status.last_load ? S_BRD : S_IDLE;
      S_BRD:   state_nxt = S_BDIFF;
      S_BDIFF: state_nxt = status.skip ? S_BRROW : S_BMUL;
      S_BMUL:  state_nxt = S_BDIV;
      S_BDIV:  if (status.div_last) state_nxt = S_BRROW;
      S_BRROW: state_nxt = status.bin_valid ? S_BWROW : S_BNEXT;
      S_BWROW: state_nxt = S_BNEXT;
      S_BNEXT: state_nxt = status.last_col ? S_ERD : S_BRD;
      S_ERD:   state_nxt = S_ECAP;
      S_ECAP:  state_nxt = S_EWAIT;
      S_EWAIT: begin
        if (status.out_fire) begin
          state_nxt = status.out_last ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.take     = (state_r == S_IDLE) && in_valid;
    cmd.store    = (state_r == S_STORE);
    cmd.range_ld = (state_r == S_BRD);
    cmd.diff     = (state_r == S_BDIFF);
    cmd.mul      = (state_r == S_BMUL);
    cmd.div      = (state_r == S_BDIV);
    cmd.row_wr   = (state_r == S_BWROW);
    cmd.col_next = (state_r == S_BNEXT);
    cmd.emit_sel = (state_r == S_ERD) || (state_r == S_ECAP) || (state_r == S_EWAIT);
    cmd.cap      = (state_r == S_ECAP);
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ design/mmb_dp.sv @@
// Datapath: config registers, scaling multiplier, min/max tracking, scaled sample RAM, bin
// divider, row map RAM and output register. Depends on mmb_pkg and mmb_ram.
`timescale 1ns / 1ps
module mmb_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [mmb_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mmb_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic signed [mmb_pkg::SAMPLE_W-1:0]    in_sample_value,
  input  logic                                   out_stall,
  input  mmb_pkg::mmb_cmd_t                      cmd,
  output mmb_pkg::mmb_status_t                   status,
  output logic                                   out_valid,
  output logic [mmb_pkg::ROW_W-1:0]              out_row_bits,
  output logic [mmb_pkg::IDX_W-1:0]              out_row_index,
  output logic                                   out_last_row
);
  import mmb_pkg::*;

  logic [CNT_W-1:0]          sample_count_r;
  logic [SCALE_W-1:0]        scale_factor_r;
  logic [CNT_W-1:0]          load_count_r;
  logic signed [DATA_W-1:0]  prod_r;
  logic signed [DATA_W-1:0]  min_r;
  logic signed [DATA_W-1:0]  max_r;
  logic [DATA_W-1:0]         range_r;
  logic [DATA_W-1:0]         diff_r;
  logic [NUM_W-1:0]          num_r;
  logic [NUM_W-1:0]          dsr_r;
  logic [Q_W-1:0]            q_r;
  logic [STEP_W-1:0]         step_r;
  logic [IDX_W-1:0]          col_r;
  logic [IDX_W-1:0]          row_r;
  logic                      out_valid_r;
  logic [ROW_W-1:0]          out_bits_r;
  logic [IDX_W-1:0]          out_index_r;
  logic                      out_last_r;

  logic [CNT_W-1:0]          blk_n;
  logic [CNT_W-1:0]          blk_n_m1;
  logic [IDX_W-1:0]          ld_idx;
  logic                      first;
  logic signed [DATA_W:0]    prod_full;
  logic signed [DATA_W-1:0]  min_nxt;
  logic signed [DATA_W-1:0]  max_nxt;
  logic signed [DATA_W-1:0]  x_val;
  logic [DATA_W-1:0]         scaled_rd;
  logic [ROW_W-1:0]          row_rd;
  logic                      ge;
  logic                      out_fire;
  logic                      row_we;
  logic [IDX_W-1:0]          row_waddr;
  logic [ROW_W-1:0]          row_wdata;
  logic [IDX_W-1:0]          row_raddr;

  always_comb begin
    blk_n = sample_count_r;
    if (sample_count_r == '0) begin
      blk_n = CNT_W'(1);
    end else if (sample_count_r > CNT_W'(MAX_SAMPLES)) begin
      blk_n = CNT_W'(MAX_SAMPLES);
    end
  end
  assign blk_n_m1 = blk_n - CNT_W'(1);

  assign ld_idx    = (load_count_r >= blk_n) ? '0 : load_count_r[IDX_W-1:0];
  assign first     = (ld_idx == '0);
  assign prod_full = in_sample_value * $signed({1'b0, scale_factor_r});

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (first) begin
      min_nxt = prod_r;
      max_nxt = (prod_r > 0) ? prod_r : '0;
    end else begin
      if (prod_r < min_r) min_nxt = prod_r;
      if (prod_r > max_r) max_nxt = prod_r;
    end
  end

  assign x_val = $signed(scaled_rd);
  assign ge    = (num_r >= dsr_r);
  assign out_fire = out_valid_r && !out_stall;

  mmb_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES)) u_scaled_ram (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (ld_idx),
    .wr_data (prod_r),
    .rd_addr (col_r),
    .rd_data (scaled_rd)
  );

  assign row_we    = cmd.store || cmd.row_wr;
  assign row_waddr = cmd.store ? ld_idx : q_r[IDX_W-1:0];
  assign row_wdata = cmd.store ? '0 : (row_rd | (ROW_W'(1) << col_r));
  assign row_raddr = cmd.emit_sel ? row_r : q_r[IDX_W-1:0];

  mmb_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SAMPLES)) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_data (row_wdata),
    .rd_addr (row_raddr),
    .rd_data (row_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SAMPLE_COUNT_RST;
      scale_factor_r <= SCALE_FACTOR_RST;
      load_count_r   <= '0;
      min_r          <= '0;
      max_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT: begin
            sample_count_r <= cfg_wdata[CNT_W-1:0];
            load_count_r   <= '0;
          end
          CFG_SCALE_FACTOR: scale_factor_r <= cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.store) begin
        min_r        <= min_nxt;
        max_r        <= max_nxt;
        load_count_r <= {1'b0, ld_idx} + CNT_W'(1);
      end
      if (cmd.cap) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
        if (status.out_last) load_count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      prod_r <= prod_full[DATA_W-1:0];
    end
    if (cmd.store) begin
      col_r <= '0;
      row_r <= '0;
    end
    if (cmd.range_ld) begin
      range_r <= DATA_W'(max_r - min_r);
    end
    if (cmd.diff) begin
      diff_r <= DATA_W'(x_val - min_r);
      q_r    <= '0;
    end
    if (cmd.mul) begin
      num_r  <= NUM_W'(diff_r) * NUM_W'(blk_n) + NUM_W'(range_r) - NUM_W'(1);
      dsr_r  <= NUM_W'(range_r) << (Q_W - 1);
      step_r <= '0;
      q_r    <= '0;
    end
    if (cmd.div) begin
      num_r  <= ge ? (num_r - dsr_r) : num_r;
      dsr_r  <= dsr_r >> 1;
      q_r    <= {q_r[Q_W-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.col_next) begin
      col_r <= col_r + IDX_W'(1);
    end
    if (cmd.cap) begin
      out_bits_r  <= row_rd;
      out_index_r <= row_r;
      out_last_r  <= ({1'b0, row_r} == blk_n_m1);
    end
    if (out_fire) begin
      row_r <= row_r + IDX_W'(1);
    end
  end

  always_comb begin
    status           = '0;
    status.last_load = (({1'b0, ld_idx} + CNT_W'(1)) == blk_n);
    status.skip      = (x_val <= min_r) || (range_r == '0);
    status.div_last  = (step_r == STEP_W'(Q_W - 1));
    status.bin_valid = (q_r < blk_n);
    status.last_col  = ({1'b0, col_r} == blk_n_m1);
    status.out_fire  = out_fire;
    status.out_last  = out_last_r;
  end

  assign out_valid     = out_valid_r;
  assign out_row_bits  = out_bits_r;
  assign out_row_index = out_index_r;
  assign out_last_row  = out_last_r;

`ifndef SYNTHESIS
  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.row_wr || cmd.col_next) |-> (q_r <= blk_n))
    else $error("bin above block size");
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.store) |-> (min_r <= max_r))
    else $error("running min above running max");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_count_r <= blk_n)
    else $error("load count beyond block size");
  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> cmd.emit_sel)
    else $error("row presented outside emit phase");
`endif

endmodule

@@ design/min_max_bin_one_hot_encoder.sv @@
// Top level of the min/max bin one-hot encoder: controller plus datapath.
// Depends on mmb_pkg, mmb_ctrl, mmb_dp (and mmb_ram through mmb_dp).
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_sample_value
//   out      output     out_valid/out_stall out_row_bits, out_row_index, out_last_row
//   cfg      input      cfg_wr_en           cfg_index, cfg_wdata
//
// Each sample loads as a multiply, then a store and min/max update. The last sample
// of a block starts the bin pass, per sample: read, diff from min, multiply, 7-step
// restoring divide, row read and write, next column; no multiply or divide if the
// sample sits at the minimum or range is 0, no row write if its bin equals the block
// size and marks no row. Rows exit via the row map RAM read port after any stall.
// Reset is synchronous; the RAMs are not cleared, rows are zeroed as samples load.
`timescale 1ns / 1ps
module min_max_bin_one_hot_encoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [mmb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mmb_pkg::SAMPLE_W-1:0] in_sample_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mmb_pkg::ROW_W-1:0]           out_row_bits,
  output logic [mmb_pkg::IDX_W-1:0]           out_row_index,
  output logic                                out_last_row
);
  import mmb_pkg::*;

  mmb_cmd_t    cmd;
  mmb_status_t status;

  mmb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mmb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_sample_value (in_sample_value),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_row_bits    (out_row_bits),
    .out_row_index   (out_row_index),
    .out_last_row    (out_last_row)
  );

endmodule

@@ dv/tb_min_max_bin_one_hot_encoder.sv @@
// Self-checking testbench for min_max_bin_one_hot_encoder: directed corner blocks, then
// randomized blocks under three sender/receiver idling mixes, checked row by row.
// Depends on mmb_pkg and the design top; holds its own bin and row-map predictor.
`timescale 1ns / 1ps

typedef struct packed {
  logic [mmb_pkg::ROW_W-1:0] bits;
  logic [mmb_pkg::IDX_W-1:0] index;
  logic                      last;
} map_row_t;

class bin_row_scoreboard;
  logic [mmb_pkg::CNT_W-1:0]   sample_count;
  logic [mmb_pkg::SCALE_W-1:0] scale_factor;
  int                          scaled [mmb_pkg::MAX_SAMPLES];
  int                          run_min;
  int                          run_max;
  int                          loaded;
  map_row_t                    expected_rows [$];
  int                          mismatches;

  function new();
    sample_count = mmb_pkg::SAMPLE_COUNT_RST;
    scale_factor = mmb_pkg::SCALE_FACTOR_RST;
    run_min      = 0;
    run_max      = 0;
    loaded       = 0;
    mismatches   = 0;
  endfunction

  function int block_len();
    if (sample_count == 0) return 1;
    if (sample_count > mmb_pkg::MAX_SAMPLES) return mmb_pkg::MAX_SAMPLES;
    return int'(sample_count);
  endfunction

  function void write_reg(logic [mmb_pkg::CFG_IDX_W-1:0] index,
                          logic [mmb_pkg::CFG_DATA_W-1:0] data);
    if (index == mmb_pkg::CFG_SAMPLE_COUNT) begin
      sample_count = data[mmb_pkg::CNT_W-1:0];
      loaded       = 0;
    end else if (index == mmb_pkg::CFG_SCALE_FACTOR) begin
      scale_factor = data[mmb_pkg::SCALE_W-1:0];
    end
  endfunction

  function int bin_of(int x, int n);
    longint spread;
    longint offset;
    longint q;
    if (x <= run_min) return 0;
    spread = longint'(run_max) - longint'(run_min);
    if (spread == 0) return 0;
    offset = longint'(x) - longint'(run_min);
    q = (offset * n + spread - 1) / spread;
    if (q > n) q = n;
    return int'(q);
  endfunction

  function void load_sample(logic signed [mmb_pkg::SAMPLE_W-1:0] value);
    int       n;
    int       slot;
    int       s;
    int       rr;
    int       c;
    int       col_bins [mmb_pkg::MAX_SAMPLES];
    map_row_t r;
    n = block_len();
    s = int'(longint'(value) * longint'(scale_factor));
    slot = (loaded >= n) ? 0 : loaded;
    if (slot == 0) begin
      run_min = s;
      run_max = 0;
    end
    if (s < run_min) run_min = s;
    if (s > run_max) run_max = s;
    scaled[slot] = s;
    loaded = slot + 1;
    if (loaded < n) return;
    for (c = 0; c < n; c++) col_bins[c] = bin_of(scaled[c], n);
    for (rr = 0; rr < n; rr++) begin
      r.bits = '0;
      for (c = 0; c < n; c++) begin
        if (col_bins[c] == rr) r.bits[c] = 1'b1;
      end
      r.index = mmb_pkg::IDX_W'(rr);
      r.last  = (rr == n - 1);
      expected_rows = {expected_rows, r};
    end
    loaded = 0;
  endfunction

  task note_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task check_row(map_row_t got);
    map_row_t want;
    if (expected_rows.size() == 0) begin
      note_mismatch($sformatf("row %0d arrived with none expected", got.index));
      return;
    end
    want = expected_rows.pop_front();
    if (got.bits != want.bits)
      note_mismatch($sformatf("row %0d bits %h, want %h", want.index, got.bits, want.bits));
    if (got.index != want.index)
      note_mismatch($sformatf("row index %0d, want %0d", got.index, want.index));
    if (got.last != want.last)
      note_mismatch($sformatf("row %0d last %0b, want %0b", want.index, got.last, want.last));
  endtask

  function int pending();
    return expected_rows.size();
  endfunction
endclass

module tb_min_max_bin_one_hot_encoder;
  import mmb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 30;

  typedef enum int {SPREAD, CLUSTER, POSITIVE, NEGATIVE, FLAT, CORNERS} value_style_t;

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index       = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata       = '0;
  logic                       in_valid        = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_value = '0;
  logic                       out_valid;
  logic                       out_stall       = 1'b0;
  logic [ROW_W-1:0]           out_row_bits;
  logic [IDX_W-1:0]           out_row_index;
  logic                       out_last_row;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  bin_row_scoreboard rows_sb = new();

  min_max_bin_one_hot_encoder dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      rows_sb.check_row({out_row_bits, out_row_index, out_last_row});
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rows_sb.load_sample(value);
    @(negedge clk);
  endtask

  task automatic wait_rows_done();
    in_valid <= 1'b0;
    while (rows_sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rows_sb.write_reg(index, data);
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] scale_choice();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_value(value_style_t style,
                                                            logic signed [SAMPLE_W-1:0] base);
    logic signed [SAMPLE_W-1:0] corner_values [5];
    corner_values = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1};
    case (style)
      CLUSTER:  return 16'(base + $urandom_range(6) - 3);
      POSITIVE: return 16'($urandom_range(32767));
      NEGATIVE: return 16'(-$urandom_range(32768, 1));
      FLAT:     return base;
      CORNERS:  return corner_values[$urandom_range(4)];
      default:  return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int budget, input bit with_full_map);
    int                         sent;
    int                         n;
    int                         blocks;
    int                         b;
    int                         k;
    int                         len;
    int                         cut;
    logic [CFG_DATA_W-1:0]      count_word;
    value_style_t               style;
    logic signed [SAMPLE_W-1:0] base;
    sent = 0;
    while (sent < budget) begin
      wait_rows_done();
      if (with_full_map) begin
        count_word    = $urandom_range(1) ? 16'd64 : 16'(65 + $urandom_range(62));
        blocks        = 1;
        with_full_map = 1'b0;
      end else begin
        case ($urandom_range(9))
          0:       count_word = '0;
          1:       count_word = 16'(65 + $urandom_range(62));
          default: count_word = 16'($urandom_range(12, 1));
        endcase
        blocks = $urandom_range(3, 1);
      end
      if ($urandom_range(3) == 0) count_word[15:7] = 9'($urandom);
      write_reg(CFG_SAMPLE_COUNT, count_word);
      if ($urandom_range(1)) write_reg(CFG_SCALE_FACTOR, scale_choice());
      n = rows_sb.block_len();
      for (b = 0; b < blocks; b++) begin
        style = value_style_t'($urandom_range(5));
        base  = 16'($urandom);
        len   = ($urandom_range(7) == 0) ? $urandom_range(n - 1) : n;
        cut   = ($urandom_range(7) == 0) ? $urandom_range(n - 1) : -1;
        for (k = 0; k < len; k++) begin
          if (k == cut) begin
            wait_rows_done();
            write_reg(CFG_SCALE_FACTOR, scale_choice());
          end
          send_sample(pick_value(style, base));
          sent++;
        end
        if (len < n) break;
        if ($urandom_range(5) == 0) wait_rows_done();
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_reg(CFG_SAMPLE_COUNT, 16'd4);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(-16'sd1);

    wait_rows_done();
    write_reg(CFG_SAMPLE_COUNT, 16'd3);
    send_sample(16'sd5);
    send_sample(16'sd5);
    send_sample(16'sd5);

    // drop a partly loaded block
    send_sample(-16'sd9);
    send_sample(16'sd40);
    wait_rows_done();
    write_reg(CFG_SAMPLE_COUNT, 16'd2);
    send_sample(16'sd40);
    send_sample(-16'sd9);

    // change scaling between the two samples of a block
    send_sample(16'sh7FFF);
    wait_rows_done();
    write_reg(CFG_SCALE_FACTOR, 16'hFFFF);
    send_sample(16'sh8000);

    wait_rows_done();
    write_reg(CFG_SAMPLE_COUNT, 16'hFF80);
    send_sample(16'sh1234);
    send_sample(-16'sd5);

    wait_rows_done();
    write_reg(CFG_SAMPLE_COUNT, 16'd3);
    write_reg(CFG_SCALE_FACTOR, 16'd0);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    send_sample(16'sd7);

    send_idle_pct  = 24;
    recv_stall_pct = 71;
    run_phase(75, 1'b1);
    send_idle_pct  = 71;
    recv_stall_pct = 24;
    run_phase(75, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(75, 1'b1);

    wait_rows_done();
    if (rows_sb.pending() != 0)
      rows_sb.note_mismatch($sformatf("%0d rows never arrived", rows_sb.pending()));
    if (rows_sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
